/* design/mst_pkg.sv */
//------------------------------------------------------------------------------
// mst_pkg
// Shared types and codes for the matrix stack vertex transform core.
//------------------------------------------------------------------------------
package mst_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH      = 2'd0,
        ACT_POP       = 2'd1,
        ACT_TRANSFORM = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_WZERO     = 3'd4
    } status_t;

    localparam int ELEM_W = 32;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        logic signed [79:0] max_v;
        logic signed [79:0] min_v;
        max_v = 80'sd2147483647;
        min_v = -80'sd2147483648;
        if (v > max_v)
            sat32 = 32'sh7fffffff;
        else if (v < min_v)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

/* design/mst_if.sv */
//------------------------------------------------------------------------------
// mst_in_if / mst_out_if
// Valid/ready channels for input items and result words.
//------------------------------------------------------------------------------
interface mst_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [1:0]         row_index;
    logic signed [31:0] elem_a;
    logic signed [31:0] elem_b;
    logic signed [31:0] elem_c;
    logic signed [31:0] elem_d;
    modport source (output valid, action, row_index, elem_a, elem_b, elem_c, elem_d,
                    input ready);
    modport sink   (input valid, action, row_index, elem_a, elem_b, elem_c, elem_d,
                    output ready);
endinterface

interface mst_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               behind_eye;
    logic [2:0]         status;
    logic [4:0]         depth_now;
    modport source (output valid, out_x, out_y, out_z, behind_eye, status, depth_now,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, behind_eye, status, depth_now,
                    output ready);
endinterface

/* design/mst_divider.sv */
//------------------------------------------------------------------------------
// mst_divider
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
//------------------------------------------------------------------------------
module mst_divider
    import mst_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W:0]   quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   q_reg, q_next;
    logic [DEN_W:0]     r_reg, r_next;
    logic [DEN_W-1:0]   d_reg, d_next;
    logic               neg_reg, neg_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DEN_W+1:0]   trial;
    logic [NUM_W:0]     qext;

    // One shift-subtract step per cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            d_next    = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg_next  = num[NUM_W-1] ^ den[DEN_W-1];
            r_next    = '0;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[NUM_W-1]} - {2'b00, d_reg};
            if (!trial[DEN_W+1])
                r_next = trial[DEN_W:0];
            else
                r_next = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
            q_next   = {q_reg[NUM_W-2:0], ~trial[DEN_W+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign qext = {1'b0, q_reg};
    assign quot = neg_reg ? -$signed(qext) : $signed(qext);
    assign done = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero count");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

endmodule

/* design/mst_mac.sv */
//------------------------------------------------------------------------------
// mst_mac
// Multiply-accumulate unit for four-term dot products with floor and saturate.
//------------------------------------------------------------------------------
module mst_mac
    import mst_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               clear,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] result
);
    logic signed [63:0] prod_reg;
    logic               en_reg;
    logic               clear_reg;
    logic signed [65:0] acc_reg;
    logic signed [65:0] acc_next;
    logic signed [65:0] shifted;

    // Register the product, then accumulate
    always_ff @(posedge clk)
    begin
        prod_reg  <= a * b;
        en_reg    <= en;
        clear_reg <= clear;
        acc_reg   <= acc_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (clear_reg)
            acc_next = '0;
        if (en_reg)
            acc_next = (clear_reg ? 66'sd0 : acc_reg) + 66'(prod_reg);
    end

    assign shifted = acc_reg >>> FRAC_BITS;
    assign result  = sat32(80'(shifted));

endmodule

/* design/matrix_stack_vertex_transform_core.sv */
//------------------------------------------------------------------------------
// matrix_stack_vertex_transform_core
// Stack of 4x4 fixed-point matrices with push, pop and vertex transform.
//------------------------------------------------------------------------------
// One item at a time. Push rows 0-2 and pop pass through staging to the result. A
// completing push on a non-empty, non-full stack runs 64 multiply-adds through one
// shared multiplier with the top matrix read from a synchronous memory.
// A transform runs 16 multiply-adds then, when w is nonzero, three serial divides
// of NUM_W bits each.
// Every item gives one result word; a held result stalls the next item.
module matrix_stack_vertex_transform_core
    import mst_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    mst_in_if.sink    in_ch,
    mst_out_if.source out_ch
);
    localparam int SW    = $clog2(STACK_DEPTH);
    localparam int AW    = SW + 4;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int NUM_W = 32 + FRAC_BITS + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_STAGE = 9'b000000010,
        S_COPY  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_WB    = 9'b000010000,
        S_XMUL  = 9'b000100000,
        S_XSAVE = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Matrix memory, one word per entry
    logic signed [31:0] mem [0:STACK_DEPTH*16-1];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic signed [31:0] mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    // Staging registers and captured item; a row 3 push marks completion
    logic signed [31:0] stage_reg [0:15];
    logic               stage_done_reg;
    logic [1:0]         act_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [5:0]         step_reg, step_next;
    logic signed [31:0] t_reg [0:3];
    logic [1:0]         dsel_reg, dsel_next;

    // Output registers
    logic               ovalid_reg, ovalid_next;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic               obeh_reg;
    status_t            ostat_reg;

    logic               accept;
    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign accept      = in_ch.valid && in_ch.ready;

    logic [SW-1:0] top_slot;
    logic [SW-1:0] new_slot;
    assign top_slot = SW'(cnt_reg - 1'b1);
    assign new_slot = SW'(cnt_reg);

    // Multiplier inputs: step = i*16 + j*4 + k for concat, i*4 + k for transform
    logic [1:0]         si, sj, sk;
    logic signed [31:0] mul_b;
    logic               mac_clear, mac_en;
    logic signed [31:0] mac_res;

    always_comb
    begin
        si = step_reg[5:4];
        sj = step_reg[3:2];
        sk = step_reg[1:0];
        if (state_reg == S_XMUL)
        begin
            si = step_reg[3:2];
            sj = 2'd0;
        end
        unique case (sk)
            2'd0: mul_b = vx_reg;
            2'd1: mul_b = vy_reg;
            2'd2: mul_b = vz_reg;
            default: mul_b = 32'sd1 <<< FRAC_BITS;
        endcase
        if (state_reg == S_MUL)
            mul_b = stage_reg[{sk, sj}];
    end

    // Memory read address leads the multiplier by its read register; step_reg selects the k term
    logic [1:0] pk_reg;
    logic       pvalid_reg;
    logic [1:0] pi_reg, pj_reg;
    logic       pmul_reg;
    logic signed [31:0] pb_reg;

    always_comb
    begin
        mem_raddr = {top_slot, si, sk};
    end

    always_ff @(posedge clk)
    begin
        pk_reg   <= sk;
        pi_reg   <= si;
        pj_reg   <= sj;
        pb_reg   <= mul_b;
        pmul_reg <= (state_reg == S_MUL) || (state_reg == S_XMUL);
    end

    assign mac_en    = pmul_reg && pvalid_reg;
    assign mac_clear = mac_en && (pk_reg == 2'd0);

    mst_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk    (clk),
        .clear  (mac_clear),
        .en     (mac_en),
        .a      (mem_rdata),
        .b      (pb_reg),
        .result (mac_res)
    );

    // Track completed dot products: fin2_reg is set while the accumulator holds a full
    // sum, once its k=3 term has passed the memory read, product and accumulator registers.
    logic       fin1_reg, fin2_reg;
    logic [1:0] fi1_reg, fj1_reg, fi2_reg, fj2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin1_reg   <= 1'b0;
            fin2_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= (state_reg == S_MUL) || (state_reg == S_XMUL);
            fin1_reg   <= mac_en && (pk_reg == 2'd3);
            fin2_reg   <= fin1_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        fi1_reg <= pi_reg;
        fj1_reg <= pj_reg;
        fi2_reg <= fi1_reg;
        fj2_reg <= fj1_reg;
    end

    // Divider: the numerator follows the component about to start, and the
    // first start takes w straight from the accumulator
    logic               div_start;
    logic signed [NUM_W-1:0] div_num;
    logic signed [31:0] div_den;
    logic               div_done;
    logic signed [NUM_W:0] div_quot;
    logic signed [31:0] div_q32;
    logic signed [31:0] tsel;

    always_comb
    begin
        unique case (dsel_next)
            2'd0: tsel = t_reg[0];
            2'd1: tsel = t_reg[1];
            default: tsel = t_reg[2];
        endcase
    end
    assign div_num = NUM_W'(tsel) <<< FRAC_BITS;
    assign div_den = (state_reg == S_XSAVE) ? mac_res : t_reg[3];
    assign div_q32 = sat32(80'(div_quot));

    mst_divider #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Control sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        dsel_next   = dsel_reg;
        ovalid_next = ovalid_reg;
        mem_we      = 1'b0;
        mem_waddr   = {new_slot, 4'd0};
        mem_wdata   = stage_reg[0];
        div_start   = 1'b0;
        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_STAGE;
            end
            S_STAGE:
            begin
                step_next = '0;
                priority if (act_reg == ACT_PUSH)
                begin
                    state_next  = S_OUT;
                    if (stage_done_reg)
                    begin
                        if (cnt_reg >= CNT_W'(STACK_DEPTH))
                            state_next = S_OUT;
                        else if (cnt_reg == '0)
                            state_next = S_COPY;
                        else
                            state_next = S_MUL;
                    end
                end
                else if (act_reg == ACT_TRANSFORM && cnt_reg != '0)
                    state_next = S_XMUL;
                else
                    state_next = S_OUT;
                // drop the top matrix on a pop
                if (act_reg == ACT_POP && cnt_reg != '0)
                    cnt_next = cnt_reg - 1'b1;
            end
            S_COPY:
            begin
                mem_we    = 1'b1;
                mem_waddr = {new_slot, step_reg[3:0]};
                mem_wdata = stage_reg[step_reg[3:0]];
                step_next = step_reg + 1'b1;
                if (step_reg[3:0] == 4'd15)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_OUT;
                end
            end
            S_MUL:
            begin
                if (step_reg != 6'd63)
                    step_next = step_reg + 1'b1;
                else
                    state_next = S_WB;
                if (fin2_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {new_slot, fi2_reg, fj2_reg};
                    mem_wdata = mac_res;
                end
            end
            S_WB:
            begin
                // drain the last dot products
                if (fin2_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {new_slot, fi2_reg, fj2_reg};
                    mem_wdata = mac_res;
                    if (fi2_reg == 2'd3 && fj2_reg == 2'd3)
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_XMUL:
            begin
                if (step_reg[3:0] != 4'd15)
                    step_next = step_reg + 1'b1;
                else
                    state_next = S_XSAVE;
            end
            S_XSAVE:
            begin
                if (fin2_reg && fi2_reg == 2'd3)
                begin
                    dsel_next = 2'd0;
                    if (mac_res == 32'sd0)
                        state_next = S_OUT;
                    else
                        state_next = S_DIV;
                    div_start = (mac_res != 32'sd0);
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    dsel_next = dsel_reg + 1'b1;
                    if (dsel_reg == 2'd2)
                        state_next = S_OUT;
                    else
                        div_start = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            step_reg   <= '0;
            dsel_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            step_reg   <= step_next;
            dsel_reg   <= dsel_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Capture the item, stage rows, collect results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg        <= in_ch.action;
            vx_reg         <= in_ch.elem_a;
            vy_reg         <= in_ch.elem_b;
            vz_reg         <= in_ch.elem_c;
            stage_done_reg <= (in_ch.row_index == 2'd3);
            if (in_ch.action == ACT_PUSH)
            begin
                stage_reg[{in_ch.row_index, 2'd0}] <= in_ch.elem_a;
                stage_reg[{in_ch.row_index, 2'd1}] <= in_ch.elem_b;
                stage_reg[{in_ch.row_index, 2'd2}] <= in_ch.elem_c;
                stage_reg[{in_ch.row_index, 2'd3}] <= in_ch.elem_d;
            end
        end
        if (state_reg == S_STAGE)
        begin
            ox_reg    <= '0;
            oy_reg    <= '0;
            oz_reg    <= '0;
            obeh_reg  <= 1'b0;
            priority if (act_reg == ACT_PUSH && stage_done_reg
                         && cnt_reg >= CNT_W'(STACK_DEPTH))
                ostat_reg <= ST_OVERFLOW;
            else if (act_reg == ACT_POP && cnt_reg == '0)
                ostat_reg <= ST_UNDERFLOW;
            else if (act_reg == ACT_TRANSFORM && cnt_reg == '0)
                ostat_reg <= ST_EMPTY;
            else
                ostat_reg <= ST_OK;
        end
        if ((state_reg == S_XMUL || state_reg == S_XSAVE) && fin2_reg)
        begin
            t_reg[fi2_reg] <= mac_res;
            if (fi2_reg == 2'd2 && mac_res[31])
                obeh_reg <= 1'b1;
            if (fi2_reg == 2'd3 && mac_res == 32'sd0)
                ostat_reg <= ST_WZERO;
        end
        if (state_reg == S_DIV && div_done)
        begin
            unique case (dsel_reg)
                2'd0: ox_reg <= div_q32;
                2'd1: oy_reg <= div_q32;
                default:
                begin
                    oz_reg <= div_q32;
                    if (div_q32[31])
                        obeh_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_ch.valid      = ovalid_reg;
    assign out_ch.out_x      = ox_reg;
    assign out_ch.out_y      = oy_reg;
    assign out_ch.out_z      = oz_reg;
    assign out_ch.behind_eye = obeh_reg;
    assign out_ch.status     = ostat_reg;
    assign out_ch.depth_now  = 5'(cnt_reg);

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count out of range");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("second item taken while busy");

endmodule

/* test/mst_transform_checker.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// mst_transform_checker
// Watches both channels of the matrix stack core, keeps its own copy of the
// matrix stack, works out the result word of every accepted input word and
// compares it field by field with the words the core returns, in order.
//------------------------------------------------------------------------------
module mst_transform_checker
    import mst_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
)
(
    input  logic clk,
    input  logic rst_n,
    mst_in_if    in_ch,
    mst_out_if   out_ch,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               behind;
        status_t            status;
        logic [4:0]         depth;
    } vertex_word_t;

    logic signed [31:0] stack_mem [STACK_DEPTH][16];
    logic signed [31:0] staged    [16];
    int                 depth;
    vertex_word_t       expected_words [$];

    assign pending = expected_words.size();

    // Clamp a wide value to the 32-bit signed range
    function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
        if (v > 80'sd2147483647)
            return 32'sh7fffffff;
        if (v < -80'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Four-term fixed-point dot product, floor shift then clamp
    function automatic logic signed [31:0] fx_dot(input logic signed [31:0] a [4],
                                                  input logic signed [31:0] b [4]);
        logic signed [79:0] acc;
        acc = '0;
        for (int k = 0; k < 4; k++)
            acc += 80'(a[k]) * 80'(b[k]);
        return clamp32(acc >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] fx_div(input logic signed [31:0] t,
                                                  input logic signed [31:0] w);
        logic signed [79:0] num;
        logic signed [79:0] den;
        num = 80'(t) <<< FRAC_BITS;
        den = 80'(w);
        return clamp32(num / den);
    endfunction

    // Apply one input word to the stack copy and return the expected result
    function automatic vertex_word_t apply_word(input action_t act, input logic [1:0] row,
                                                input logic signed [31:0] e [4]);
        vertex_word_t            r;
        logic signed [31:0]      a [4];
        logic signed [31:0]      b [4];
        logic signed [31:0]      t [4];
        logic signed [31:0]      prod [16];
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                for (int k = 0; k < 4; k++)
                    staged[row * 4 + k] = e[k];
                if (row == 2'd3) begin
                    if (depth >= STACK_DEPTH) begin
                        r.status = ST_OVERFLOW;
                    end else if (depth == 0) begin
                        for (int k = 0; k < 16; k++)
                            stack_mem[0][k] = staged[k];
                        depth = 1;
                    end else begin
                        for (int i = 0; i < 4; i++)
                            for (int j = 0; j < 4; j++) begin
                                for (int k = 0; k < 4; k++) begin
                                    a[k] = stack_mem[depth - 1][i * 4 + k];
                                    b[k] = staged[k * 4 + j];
                                end
                                prod[i * 4 + j] = fx_dot(a, b);
                            end
                        for (int k = 0; k < 16; k++)
                            stack_mem[depth][k] = prod[k];
                        depth++;
                    end
                end
            end
            ACT_POP: begin
                if (depth == 0)
                    r.status = ST_UNDERFLOW;
                else
                    depth--;
            end
            ACT_TRANSFORM: begin
                if (depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    b[0] = e[0];
                    b[1] = e[1];
                    b[2] = e[2];
                    b[3] = 32'sd1 <<< FRAC_BITS;
                    for (int i = 0; i < 4; i++) begin
                        for (int k = 0; k < 4; k++)
                            a[k] = stack_mem[depth - 1][i * 4 + k];
                        t[i] = fx_dot(a, b);
                    end
                    r.behind = t[2] < 0;
                    if (t[3] == 0) begin
                        r.status = ST_WZERO;
                    end else begin
                        r.x = fx_div(t[0], t[3]);
                        r.y = fx_div(t[1], t[3]);
                        r.z = fx_div(t[2], t[3]);
                        if (r.z < 0)
                            r.behind = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.depth = depth[4:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint exp_v, input longint got_v);
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_v, got_v);
        fail_count++;
    endtask

    // Predict on input accepts, compare on output accepts
    always @(posedge clk or negedge rst_n) begin
        logic signed [31:0] e [4];
        vertex_word_t       exp_w;
        if (!rst_n) begin
            depth = 0;
            fail_count = 0;
            expected_words.delete();
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                e[0] = in_ch.elem_a;
                e[1] = in_ch.elem_b;
                e[2] = in_ch.elem_c;
                e[3] = in_ch.elem_d;
                expected_words.push_back(apply_word(action_t'(in_ch.action),
                                                    in_ch.row_index, e));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with nothing expected", $realtime);
                    fail_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (out_ch.out_x !== exp_w.x)
                        report_mismatch("out_x", exp_w.x, out_ch.out_x);
                    if (out_ch.out_y !== exp_w.y)
                        report_mismatch("out_y", exp_w.y, out_ch.out_y);
                    if (out_ch.out_z !== exp_w.z)
                        report_mismatch("out_z", exp_w.z, out_ch.out_z);
                    if (out_ch.behind_eye !== exp_w.behind)
                        report_mismatch("behind_eye", exp_w.behind, out_ch.behind_eye);
                    if (out_ch.status !== exp_w.status)
                        report_mismatch("status", exp_w.status, out_ch.status);
                    if (out_ch.depth_now !== exp_w.depth)
                        report_mismatch("depth_now", exp_w.depth, out_ch.depth_now);
                end
            end
        end
    end

endmodule

/* test/matrix_stack_vertex_transform_core_tb.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// matrix_stack_vertex_transform_core_tb
// Drives push, pop, transform and unused-action words into the core under
// random idling on both channels, with a long output stall and a full drain,
// and reports the verdict from the checker's failure and pending counts.
//------------------------------------------------------------------------------
module matrix_stack_vertex_transform_core_tb;
    import mst_pkg::*;

    localparam int ONE = 32'sd1 <<< 16;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   hold_left;
    int   words_sent;
    logic [3:0] rows_seen;

    mst_in_if  in_ch();
    mst_out_if out_ch();

    matrix_stack_vertex_transform_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    mst_transform_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when requested
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= $urandom_range(99) >= rx_idle_pct;
            end
        end
    end

    task automatic send_word(input action_t act, input logic [1:0] row,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.row_index <= row;
        in_ch.elem_a    <= a;
        in_ch.elem_b    <= b;
        in_ch.elem_c    <= c;
        in_ch.elem_d    <= d;
        do @(posedge clk); while (!in_ch.ready);
        if (act == ACT_PUSH)
            rows_seen[row] = 1'b1;
        words_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_elem();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return $urandom;
        if (pick < 30)
            return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        if (pick < 45)
            return ($urandom_range(8) - 4) <<< 16;
        return $urandom_range(32'h80000) - 32'h40000;
    endfunction

    // Push a matrix with mostly near-projective content
    task automatic push_matrix();
        logic [31:0] w_row [4];
        for (int r = 0; r < 3; r++)
            send_word(ACT_PUSH, 2'(r), rand_elem(), rand_elem(), rand_elem(), rand_elem());
        if ($urandom_range(99) < 65) begin
            w_row[0] = $urandom_range(3) == 0 ? rand_elem() : 32'd0;
            w_row[1] = $urandom_range(3) == 0 ? rand_elem() : 32'd0;
            w_row[2] = $urandom_range(1) ? $urandom_range(32'h20000) - 32'h10000 : 32'd0;
            w_row[3] = ONE + $urandom_range(32'h1000) - 32'h800;
        end else begin
            foreach (w_row[k])
                w_row[k] = rand_elem();
        end
        send_word(ACT_PUSH, 2'd3, w_row[0], w_row[1], w_row[2], w_row[3]);
    endtask

    task automatic random_step();
        int pick;
        int row;
        pick = $urandom_range(99);
        if (pick < 35) begin
            push_matrix();
        end else if (pick < 45) begin
            // stray row, completing only once every row has been staged
            row = $urandom_range(3);
            if (row == 3 && rows_seen != 4'hf)
                row = 0;
            send_word(ACT_PUSH, 2'(row), rand_elem(), rand_elem(), rand_elem(), rand_elem());
        end else if (pick < 55) begin
            repeat ($urandom_range(1, 20))
                send_word(ACT_POP, 2'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 4))
                send_word(ACT_TRANSFORM, 2'($urandom), rand_elem(), rand_elem(), rand_elem(),
                          $urandom);
        end else begin
            send_word(ACT_NONE, 2'($urandom), $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= ACT_NONE;
        in_ch.row_index <= 2'd0;
        in_ch.elem_a    <= '0;
        in_ch.elem_b    <= '0;
        in_ch.elem_c    <= '0;
        in_ch.elem_d    <= '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = 0;
        words_sent  = 0;
        rows_seen   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty stack cases, unused action, identity, extremes, w zero
        send_word(ACT_POP, 2'd0, '0, '0, '0, '0);
        send_word(ACT_TRANSFORM, 2'd3, ONE, ONE, ONE, '1);
        send_word(ACT_NONE, 2'd3, '1, '1, '1, '1);
        send_word(ACT_PUSH, 2'd0, ONE, 0, 0, 0);
        send_word(ACT_PUSH, 2'd1, 0, ONE, 0, 0);
        send_word(ACT_PUSH, 2'd2, 0, 0, ONE, 0);
        send_word(ACT_PUSH, 2'd3, 0, 0, 0, ONE);
        send_word(ACT_TRANSFORM, 2'd0, 32'h7fffffff, 32'h80000000, 32'hffffffff, '0);
        send_word(ACT_PUSH, 2'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_word(ACT_PUSH, 2'd1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_word(ACT_PUSH, 2'd2, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_word(ACT_PUSH, 2'd3, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_word(ACT_TRANSFORM, 2'd1, 32'h80000000, 32'h7fffffff, 32'h80000000, '0);
        send_word(ACT_POP, 2'd0, '0, '0, '0, '0);
        // zero bottom row on top of identity: w comes out zero
        send_word(ACT_PUSH, 2'd3, 0, 0, 0, 0);
        send_word(ACT_TRANSFORM, 2'd2, ONE, -ONE, -ONE, '0);
        send_word(ACT_POP, 2'd0, '0, '0, '0, '0);
        send_word(ACT_POP, 2'd0, '0, '0, '0, '0);
        send_word(ACT_POP, 2'd0, '0, '0, '0, '0);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = phase == 0 ? 33 : (phase == 1 ? 81 : 0);
            rx_idle_pct = phase == 0 ? 81 : (phase == 1 ? 33 : 0);
            // long output hold-off while words keep coming
            if (phase == 0)
                hold_left = 800;
            while (words_sent < 20 + (phase + 1) * 280)
                random_step();
            // pause until every result is back
            drain_results();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
